### rtl/core/lfu_pkg.sv
package lfu_pkg;

	localparam int CAPACITY_DEF   = 8;
	localparam int COUNT_BITS_DEF = 16;
	localparam int CAP_W          = 4;
	localparam int KEY_W          = 32;
	localparam int VAL_W          = 31;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic              action;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  write_value;
	} lfu_in_t;

	typedef struct packed {
		logic              found;
		logic [VAL_W-1:0]  read_value;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
	} lfu_out_t;

	// commands broadcast to every cell for one cycle
	typedef struct packed {
		logic             touch;      // hit cell: count+1, rank 0
		logic             write;      // hit cell: take new data
		logic             age_below;  // valid cells with rank below ref rank: +1
		logic             evict;      // victim cell: invalidate
		logic             lift_above; // valid cells with rank above ref rank: -1
		logic             age_all;    // all valid cells: +1
		logic             fill;       // free cell: load new entry
	} lfu_cmd_t;

endpackage

### rtl/core/lfu_cache_lru_tiebreak.sv
// LFU cache with LRU tie break.
// Channels: in (in_valid/in_ready, in_data of lfu_in_t) carries get/put
// transactions; out (out_valid/out_ready, out_data of lfu_out_t) returns one
// result per transaction. cap_we/cap_data write capacity_in_use (write only
// while no transaction is in flight).
// Entries live in a row of CAPACITY cells; each cell compares its own key,
// and rank/count updates are broadcast to all cells in the same cycle.
// Per transaction: an accept state, a lookup state, then for a put that must
// evict a scan through the cells with one comparator, then the evict and
// fill update states and the result state. A get or a put hit goes from
// lookup to the result state; a put into a free slot passes through fill.
// One transaction at a time; the result register holds while out_ready is
// low and in_ready rises the cycle after the result is taken.
// Reset clears all entries to invalid, occupancy to zero, capacity to 8.
module lfu_cache_lru_tiebreak #(
	parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lfu_pkg::lfu_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lfu_pkg::lfu_out_t               out_data,
	input  logic                            cap_we,
	input  logic [lfu_pkg::CAP_W-1:0]       cap_data
);
	import lfu_pkg::*;

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RANK_W = IDX_W;
	localparam int OCC_W  = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_LOOK, S_SCAN, S_EVICT, S_FILL, S_OUT
	} state_t;

	state_t               state_q;
	lfu_in_t              req_q;
	lfu_out_t             res_q;
	logic [CAP_W-1:0]     cap_q;
	logic [OCC_W-1:0]     occ_q;
	logic [IDX_W-1:0]     tgt_q;
	logic [RANK_W-1:0]    ref_q;
	logic [OCC_W-1:0]     scan_q;
	logic                 vfound_q;
	logic [IDX_W-1:0]     vidx_q;
	logic [COUNT_BITS-1:0] vcnt_q;
	logic [RANK_W-1:0]    vrank_q;
	lfu_cmd_t             cmd;
	lfu_out_t             look_res;

	logic [IDX_W-1:0]     sel_idx;
	logic [RANK_W-1:0]    sel_rank;

	logic [CAPACITY-1:0]  c_valid, c_hit, c_sel;
	logic [KEY_W-1:0]     c_key   [CAPACITY];
	logic [VAL_W-1:0]     c_data  [CAPACITY];
	logic [COUNT_BITS-1:0] c_count [CAPACITY];
	logic [RANK_W-1:0]    c_rank  [CAPACITY];

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			assign c_sel[g] = (sel_idx == IDX_W'(g));
			lfu_cell #(.COUNT_BITS(COUNT_BITS), .RANK_W(RANK_W)) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .sel(c_sel[g]),
				.ref_rank(sel_rank), .new_key(req_q.key), .new_val(req_q.write_value),
				.match_key(req_q.key), .valid(c_valid[g]), .hit(c_hit[g]),
				.key(c_key[g]), .data(c_data[g]), .count(c_count[g]),
				.rank(c_rank[g])
			);
		end
	endgenerate

	// hit index and first free slot (at most one hit)
	logic               any_hit, any_free;
	logic [IDX_W-1:0]   hit_idx, free_idx;
	always_comb begin
		any_hit  = 1'b0;
		hit_idx  = '0;
		any_free = 1'b0;
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (c_hit[i]) begin
				any_hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!c_valid[i]) begin
				any_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// target cell: hit cell during lookup, first free cell during fill, else tgt_q
	always_comb begin
		case (state_q)
			S_LOOK: begin
				sel_idx  = hit_idx;
				sel_rank = c_rank[hit_idx];
			end
			S_FILL: begin
				sel_idx  = free_idx;
				sel_rank = ref_q;
			end
			default: begin
				sel_idx  = tgt_q;
				sel_rank = ref_q;
			end
		endcase
	end

	logic [OCC_W:0] cap_eff;
	assign cap_eff = ({1'b0, cap_q} > (OCC_W+1)'(CAPACITY)) ? (OCC_W+1)'(CAPACITY)
	                 : (OCC_W+1)'(cap_q);

	logic [IDX_W-1:0] scan_idx;
	logic             scan_better;
	assign scan_idx = scan_q[IDX_W-1:0];
	assign scan_better = c_valid[scan_idx] && (!vfound_q ||
		c_count[scan_idx] < vcnt_q ||
		(c_count[scan_idx] == vcnt_q && c_rank[scan_idx] > vrank_q));

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	always_comb begin
		look_res       = '0;
		look_res.found = any_hit;
		if (any_hit && req_q.action == ACT_GET)
			look_res.read_value = c_data[hit_idx];
	end

	always_comb begin
		cmd = '0;
		if (state_q == S_LOOK && any_hit &&
		    (req_q.action == ACT_GET || cap_eff != '0)) begin
			cmd.touch     = 1'b1;
			cmd.age_below = 1'b1;
			cmd.write     = (req_q.action == ACT_PUT);
		end
		if (state_q == S_EVICT) begin
			cmd.evict      = 1'b1;
			cmd.lift_above = 1'b1;
		end
		if (state_q == S_FILL && any_free) begin
			cmd.fill    = 1'b1;
			cmd.age_all = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cap_we) begin
			cap_q <= cap_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= '0;
			res_q    <= '0;
			occ_q    <= '0;
			tgt_q    <= '0;
			ref_q    <= '0;
			scan_q   <= '0;
			vfound_q <= 1'b0;
			vidx_q   <= '0;
			vcnt_q   <= '0;
			vrank_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					res_q <= look_res;
					tgt_q <= hit_idx;
					ref_q <= c_rank[hit_idx];
					if (req_q.action == ACT_GET || cap_eff == '0 || any_hit) begin
						state_q <= S_OUT;
					end else if ((OCC_W+1)'(occ_q) >= cap_eff) begin
						scan_q   <= '0;
						vfound_q <= 1'b0;
						state_q  <= S_SCAN;
					end else begin
						state_q <= S_FILL;
					end
				end
				S_SCAN: begin
					if (scan_better) begin
						vfound_q <= 1'b1;
						vidx_q   <= scan_idx;
						vcnt_q   <= c_count[scan_idx];
						vrank_q  <= c_rank[scan_idx];
					end
					if (scan_q == OCC_W'(CAPACITY - 1)) begin
						state_q <= vfound_q || scan_better ? S_EVICT : S_FILL;
						tgt_q   <= scan_better ? scan_idx : vidx_q;
						ref_q   <= scan_better ? c_rank[scan_idx] : vrank_q;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_EVICT: begin
					res_q <= {res_q.found, res_q.read_value, 1'b1, c_key[tgt_q]};
					if (occ_q != '0)
						occ_q <= occ_q - 1'b1;
					state_q <= S_FILL;
				end
				S_FILL: begin
					tgt_q <= free_idx;
					if (any_free)
						occ_q <= occ_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY))
		else $error("occupancy beyond capacity");
	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (occ_q == OCC_W'($countones(c_valid))))
		else $error("occupancy out of step with valid cells");
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(c_hit))
		else $error("key held in two cells");
	a_evict_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVICT) |-> c_valid[tgt_q])
		else $error("victim not valid");
`endif

endmodule

### rtl/core/lfu_cell.sv
module lfu_cell #(
	parameter int COUNT_BITS = 16,
	parameter int RANK_W     = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lfu_pkg::lfu_cmd_t            cmd,
	input  logic                         sel,       // this cell is the target
	input  logic [RANK_W-1:0]            ref_rank,
	input  logic [lfu_pkg::KEY_W-1:0]    new_key,
	input  logic [lfu_pkg::VAL_W-1:0]    new_val,
	input  logic [lfu_pkg::KEY_W-1:0]    match_key,
	output logic                         valid,
	output logic                         hit,
	output logic [lfu_pkg::KEY_W-1:0]    key,
	output logic [lfu_pkg::VAL_W-1:0]    data,
	output logic [COUNT_BITS-1:0]        count,
	output logic [RANK_W-1:0]            rank
);
	import lfu_pkg::*;

	logic                  valid_q;
	logic [KEY_W-1:0]      key_q;
	logic [VAL_W-1:0]      data_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [RANK_W-1:0]     rank_q;

	assign valid = valid_q;
	assign key   = key_q;
	assign data  = data_q;
	assign count = count_q;
	assign rank  = rank_q;
	assign hit   = valid_q && (key_q == match_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.evict) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.fill) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.fill) begin
			key_q   <= new_key;
			data_q  <= new_val;
			count_q <= COUNT_BITS'(1);
			rank_q  <= '0;
		end else begin
			if (sel && cmd.write)
				data_q <= new_val;
			if (sel && cmd.touch) begin
				rank_q <= '0;
				if (count_q != '1)
					count_q <= count_q + 1'b1;
			end else if (valid_q) begin
				if (cmd.age_below && rank_q < ref_rank)
					rank_q <= rank_q + 1'b1;
				else if (cmd.lift_above && rank_q > ref_rank)
					rank_q <= rank_q - 1'b1;
				else if (cmd.age_all)
					rank_q <= rank_q + 1'b1;
			end
		end
	end

endmodule
